// File: design/b64_pkg.sv
package b64_pkg;

    // Classified character as it travels from the front stage to the back stage.
    typedef struct packed {
        logic [5:0] sextet;
        logic       is_pad;
        logic       is_bad;
        logic       last;
    } char_class_t;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ST_OK             = 3'd0;
    localparam logic [2:0] ST_LEADING_PAD    = 3'd1;
    localparam logic [2:0] ST_EXCESS_PAD     = 3'd2;
    localparam logic [2:0] ST_DATA_AFTER_PAD = 3'd3;
    localparam logic [2:0] ST_BAD_CHAR       = 3'd4;
    localparam logic [2:0] ST_DISCONT_PAD    = 3'd5;
    localparam logic [2:0] ST_ONE_LEFTOVER   = 3'd6;
    localparam logic [2:0] ST_BAD_PADDING    = 3'd7;

endpackage

// File: design/b64_front.sv
module b64_front
    import b64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_char,
    input  logic        last_char,
    input  logic        queue_full,
    output logic        queue_push,
    output char_class_t queue_data
);

    function automatic char_class_t classify_char(input logic [7:0] ch, input logic last);
        char_class_t c;
        c.sextet = 6'd0;
        c.is_pad = (ch == PAD_CHAR);
        c.is_bad = 1'b0;
        c.last   = last;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            c.sextet = 6'(ch - 8'h41);
        end
        else if (ch >= 8'h61 && ch <= 8'h7A) begin
            c.sextet = 6'(ch - 8'h47);
        end
        else if (ch >= 8'h30 && ch <= 8'h39) begin
            c.sextet = 6'(ch + 8'd4);
        end
        else if (ch == 8'h2B) begin
            c.sextet = 6'd62;
        end
        else if (ch == 8'h2F) begin
            c.sextet = 6'd63;
        end
        else begin
            c.is_bad = !c.is_pad;
        end
        return c;
    endfunction

    logic        stage_valid_reg;
    logic        stage_valid_next;
    char_class_t stage_data_reg;
    logic        accept;

    assign in_stall   = stage_valid_reg && queue_full;
    assign accept     = in_valid && !in_stall;
    assign queue_push = stage_valid_reg && !queue_full;
    assign queue_data = stage_data_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (queue_push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_data_reg <= classify_char(in_char, last_char);
        end
    end

endmodule

// File: design/b64_queue.sv
module b64_queue
    import b64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  char_class_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output char_class_t head_data
);

    char_class_t            entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("pop from empty queue");
`endif

endmodule

// File: design/b64_back.sv
module b64_back
    import b64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        head_valid,
    input  char_class_t head_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        byte_valid,
    output logic [7:0]  out_byte,
    output logic        message_end,
    output logic [2:0]  status
);

    logic       strict_reg;
    logic [1:0] quad_reg,     quad_next;
    logic [5:0] left_reg,     left_next;
    logic [1:0] pads_reg,     pads_next;
    logic       seen_reg,     seen_next;
    logic       first_reg,    first_next;
    logic       complete_reg, complete_next;
    logic [2:0] error_reg,    error_next;

    logic       out_valid_reg,   out_valid_next;
    logic       byte_valid_reg,  byte_valid_next;
    logic [7:0] out_byte_reg,    out_byte_next;
    logic       message_end_reg;
    logic [2:0] status_reg;

    logic [1:0] pads_inc;
    logic [2:0] fill_sum;

    assign pop         = head_valid && (!out_valid_reg || !out_stall);
    assign out_valid   = out_valid_reg;
    assign byte_valid  = byte_valid_reg;
    assign out_byte    = out_byte_reg;
    assign message_end = message_end_reg;
    assign status      = status_reg;

    assign pads_inc = pads_reg + 2'd1;
    assign fill_sum = {1'b0, quad_reg} + {1'b0, pads_inc};

    always_comb
    begin
        quad_next       = quad_reg;
        left_next       = left_reg;
        pads_next       = pads_reg;
        seen_next       = seen_reg;
        first_next      = 1'b0;
        complete_next   = complete_reg;
        error_next      = error_reg;
        byte_valid_next = 1'b0;
        out_byte_next   = 8'd0;

        if (error_reg == ST_OK && !complete_reg)
        begin
            if (strict_reg && first_reg && head_data.is_pad)
            begin
                error_next = ST_LEADING_PAD;
            end
            else if (head_data.is_pad)
            begin
                seen_next = 1'b1;
                if (strict_reg && quad_reg == 2'd0)
                begin
                    error_next = ST_EXCESS_PAD;
                end
                else if (quad_reg >= 2'd2)
                begin
                    pads_next = pads_inc;
                    if (fill_sum >= 3'd4)
                    begin
                        complete_next = 1'b1;
                        if (strict_reg && !head_data.last)
                        begin
                            error_next = ST_DATA_AFTER_PAD;
                        end
                    end
                end
            end
            else if (head_data.is_bad)
            begin
                if (strict_reg)
                begin
                    error_next = ST_BAD_CHAR;
                end
            end
            else if (strict_reg && seen_reg)
            begin
                error_next = ST_DISCONT_PAD;
            end
            else
            begin
                pads_next = 2'd0;
                case (quad_reg)
                    2'd0:
                    begin
                        quad_next = 2'd1;
                        left_next = head_data.sextet;
                    end
                    2'd1:
                    begin
                        quad_next       = 2'd2;
                        out_byte_next   = {left_reg, head_data.sextet[5:4]};
                        byte_valid_next = 1'b1;
                        left_next       = {2'b00, head_data.sextet[3:0]};
                    end
                    2'd2:
                    begin
                        quad_next       = 2'd3;
                        out_byte_next   = {left_reg[3:0], head_data.sextet[5:2]};
                        byte_valid_next = 1'b1;
                        left_next       = {4'b0000, head_data.sextet[1:0]};
                    end
                    default:
                    begin
                        quad_next       = 2'd0;
                        out_byte_next   = {left_reg[1:0], head_data.sextet};
                        byte_valid_next = 1'b1;
                        left_next       = 6'd0;
                    end
                endcase
            end
        end

        // A message that ends inside a quad without completed padding is reported here.
        if (head_data.last && error_next == ST_OK && !complete_next)
        begin
            if (quad_next == 2'd1)
            begin
                error_next = ST_ONE_LEFTOVER;
            end
            else if (quad_next != 2'd0)
            begin
                error_next = ST_BAD_PADDING;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg    <= 1'b0;
            quad_reg      <= 2'd0;
            left_reg      <= 6'd0;
            pads_reg      <= 2'd0;
            seen_reg      <= 1'b0;
            first_reg     <= 1'b1;
            complete_reg  <= 1'b0;
            error_reg     <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                strict_reg <= cfg_data;
            end
            if (pop)
            begin
                if (head_data.last)
                begin
                    quad_reg     <= 2'd0;
                    left_reg     <= 6'd0;
                    pads_reg     <= 2'd0;
                    seen_reg     <= 1'b0;
                    first_reg    <= 1'b1;
                    complete_reg <= 1'b0;
                    error_reg    <= ST_OK;
                end
                else
                begin
                    quad_reg     <= quad_next;
                    left_reg     <= left_next;
                    pads_reg     <= pads_next;
                    seen_reg     <= seen_next;
                    first_reg    <= first_next;
                    complete_reg <= complete_next;
                    error_reg    <= error_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_valid_reg  <= byte_valid_next;
            out_byte_reg    <= out_byte_next;
            message_end_reg <= head_data.last;
            status_reg      <= error_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (error_reg != ST_OK) |=>
            (error_reg == $past(error_reg)) || (error_reg == ST_OK && first_reg))
        else $error("error code changed inside a message");
    a_complete_pos: assert property (@(posedge clk) disable iff (!rst_n)
        complete_reg |-> (quad_reg >= 2'd2))
        else $error("padding complete at impossible quad position");
    a_message_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_data.last) |=>
            (first_reg && quad_reg == 2'd0 && error_reg == ST_OK && !complete_reg))
        else $error("state not cleared after message end");
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !byte_valid_reg) |-> (out_byte_reg == 8'd0))
        else $error("nonzero byte without byte_valid");
`endif

endmodule

// File: design/base64_strict_stream_decoder.sv
// Throughput: one character per clock cycle, sustained while the output is not stalled.
// Path: a character passes through the classification register, then the two-entry queue,
// then the decode state and output register before its result appears on the output.
// Reset (rst_n low, asynchronous): the strict-check register clears to 0, the decode state
// returns to the start of a message, the queue empties and no result is pending.
module base64_strict_stream_decoder
    import b64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       byte_valid,
    output logic [7:0] out_byte,
    output logic       message_end,
    output logic [2:0] status
);

    logic        queue_full;
    logic        queue_push;
    char_class_t queue_in;
    logic        queue_pop;
    logic        head_valid;
    char_class_t head_data;

    b64_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_char    (in_char),
        .last_char  (last_char),
        .queue_full (queue_full),
        .queue_push (queue_push),
        .queue_data (queue_in)
    );

    b64_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (queue_push),
        .push_data  (queue_in),
        .full       (queue_full),
        .pop        (queue_pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    b64_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .head_valid  (head_valid),
        .head_data   (head_data),
        .pop         (queue_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_valid  (byte_valid),
        .out_byte    (out_byte),
        .message_end (message_end),
        .status      (status)
    );

endmodule
